/* src/assert_macros.svh */
// Assertion macros for the checker file cdps_checker.sv.
// Depends on nothing; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* src/cdps_pkg.sv */
// Package for the chamfer distance block: request and status codes, sizes.
// Depends on nothing.
`default_nettype none
package cdps_pkg;
   localparam int MAX_POINTS_DEF = 256;
   localparam int COORD_BITS_DEF = 11;
   localparam int DIST_BITS = 20;
   localparam logic [1:0] REQ_ADD_FIRST  = 2'd0;
   localparam logic [1:0] REQ_ADD_SECOND = 2'd1;
   localparam logic [1:0] REQ_COMPUTE    = 2'd2;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_DROPPED = 2'd2;
endpackage
`default_nettype wire

/* src/chamfer_distance_point_sets.sv */
// Symmetric chamfer distance between two point sets held in two on-chip memories. A load
// word (add to first or second set) is taken back to back; a word of the unused request
// code is taken and ignored. A compute word finding a set empty or a load dropped is
// answered with status ST_EMPTY or ST_DROPPED and zero distance; otherwise it walks the
// sets: for each outer point every inner point is read from its memory port, one per cycle
// (a squared distance and running minimum per read), then the minimum goes through a serial
// square root of 2*COORD_BITS+20 bits (one root bit a cycle). Each direction ends in a serial
// divide (one quotient bit a cycle). From its acceptance until the result word is valid the
// input is stalled. The result then waits in an output register; load words are still taken
// meanwhile, but a further compute word is stalled until the result has been taken.
// Depends on cdps_pkg, cdps_point_ram, cdps_isqrt and cdps_divider.
`default_nettype none
module chamfer_distance_point_sets #(
   parameter int MAX_POINTS = cdps_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = cdps_pkg::COORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_type,
   input  wire logic signed [COORD_BITS-1:0]   point_x,
   input  wire logic signed [COORD_BITS-1:0]   point_y,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [cdps_pkg::DIST_BITS-1:0]      distance_q8,
   output logic [1:0]                         status
);
   localparam int AB = $clog2(MAX_POINTS);
   localparam int CNTB = AB + 1;
   localparam int PW = 2 * COORD_BITS;
   localparam int DB = COORD_BITS + 1;              // coordinate difference
   localparam int SQB = 2 * DB + 1;                 // sum of two squares
   localparam int RADB = SQB + 17;                  // d2 << 16, made even
   localparam int RADE = RADB + (RADB % 2);
   localparam int ROOTB = RADE / 2;
   localparam int SUMB = ROOTB + CNTB;
   localparam int DMAX = (1 << cdps_pkg::DIST_BITS) - 1;

   typedef enum logic [2:0] {
      S_LOAD, S_READ, S_ACC, S_SQRT, S_DIV, S_NEXTDIR, S_RESP
   } state_type;

   state_type          state_ff;
   logic [CNTB-1:0]    cnt_a_ff, cnt_b_ff;
   logic               ovf_ff;
   logic               dir_ff;                      // 0: first to second
   logic [CNTB-1:0]    i_ff, j_ff;
   logic               pend_ff;                     // a read is in flight
   logic               last_ff;
   logic [SQB-1:0]     best_ff;
   logic [SUMB-1:0]    sum_ff;
   logic [SUMB-1:0]    fwd_ff;
   logic [SUMB:0]      total;
   logic               rsp_valid_ff;
   logic [cdps_pkg::DIST_BITS-1:0] dist_ff;
   logic [1:0]         status_ff;

   logic               wr_a, wr_b;
   logic [AB-1:0]      rd_a, rd_b;
   logic [PW-1:0]      q_a, q_b, p_out, p_in;
   logic               accept;
   logic               sq_start, sq_done, dv_start, dv_done;
   logic [ROOTB-1:0]   sq_root;
   logic [SUMB-1:0]    dv_quot;
   logic signed [DB-1:0] dx, dy;
   logic signed [2*DB-1:0] dx_sq, dy_sq;
   logic [SQB-1:0]     d2;
   logic [CNTB-1:0]    n_out, n_in;

   assign accept = req_valid && !req_stall;
   // Loads may continue while a result waits; only a new compute has to hold back.
   assign req_stall = (state_ff != S_LOAD)
                      || (rsp_valid_ff && req_type == cdps_pkg::REQ_COMPUTE);
   assign wr_a = accept && req_type == cdps_pkg::REQ_ADD_FIRST && cnt_a_ff < CNTB'(MAX_POINTS);
   assign wr_b = accept && req_type == cdps_pkg::REQ_ADD_SECOND
                 && cnt_b_ff < CNTB'(MAX_POINTS);

   // Outer point index goes to the outer set, inner index to the other.
   assign rd_a = dir_ff ? j_ff[AB-1:0] : i_ff[AB-1:0];
   assign rd_b = dir_ff ? i_ff[AB-1:0] : j_ff[AB-1:0];
   assign p_out = dir_ff ? q_b : q_a;
   assign p_in  = dir_ff ? q_a : q_b;
   assign n_out = dir_ff ? cnt_b_ff : cnt_a_ff;
   assign n_in  = dir_ff ? cnt_a_ff : cnt_b_ff;

   cdps_point_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_ram_a (
      .clock(clock), .wr_en(wr_a), .wr_addr(cnt_a_ff[AB-1:0]),
      .wr_data({point_x, point_y}), .rd_addr(rd_a), .rd_data(q_a));
   cdps_point_ram #(.DEPTH(MAX_POINTS), .WIDTH(PW)) u_ram_b (
      .clock(clock), .wr_en(wr_b), .wr_addr(cnt_b_ff[AB-1:0]),
      .wr_data({point_x, point_y}), .rd_addr(rd_b), .rd_data(q_b));

   always_comb begin
      dx = DB'($signed(p_out[PW-1:COORD_BITS])) - DB'($signed(p_in[PW-1:COORD_BITS]));
      dy = DB'($signed(p_out[COORD_BITS-1:0])) - DB'($signed(p_in[COORD_BITS-1:0]));
      dx_sq = dx * dx;
      dy_sq = dy * dy;
      d2 = SQB'(unsigned'(dx_sq)) + SQB'(unsigned'(dy_sq));
      total = {1'b0, fwd_ff} + {1'b0, dv_quot};
   end

   assign sq_start = (state_ff == S_ACC) && pend_ff && last_ff;
   assign dv_start = (state_ff == S_SQRT) && sq_done && (i_ff + 1'b1 == n_out);

   cdps_isqrt #(.IN_BITS(RADE)) u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .radicand({{(RADE-SQB-16){1'b0}}, (d2 < best_ff ? d2 : best_ff), 16'd0}),
      .done(sq_done), .root(sq_root));
   cdps_divider #(.NUM_BITS(SUMB), .DEN_BITS(CNTB)) u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .numer(sum_ff + SUMB'(sq_root)), .denom(n_out), .done(dv_done), .quot(dv_quot));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         dir_ff       <= 1'b0;
      end else begin
         if (state_ff == S_RESP) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)    rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  priority if (req_type == cdps_pkg::REQ_ADD_FIRST) begin
                     if (wr_a) cnt_a_ff <= cnt_a_ff + 1'b1;
                     else      ovf_ff <= 1'b1;
                  end else if (req_type == cdps_pkg::REQ_ADD_SECOND) begin
                     if (wr_b) cnt_b_ff <= cnt_b_ff + 1'b1;
                     else      ovf_ff <= 1'b1;
                  end else if (req_type == cdps_pkg::REQ_COMPUTE) begin
                     priority if (cnt_a_ff == '0 || cnt_b_ff == '0) begin
                        status_ff <= cdps_pkg::ST_EMPTY;
                        state_ff  <= S_RESP;
                     end else if (ovf_ff) begin
                        status_ff <= cdps_pkg::ST_DROPPED;
                        state_ff  <= S_RESP;
                     end else begin
                        status_ff <= cdps_pkg::ST_OK;
                        dir_ff    <= 1'b0;
                        i_ff      <= '0;
                        j_ff      <= '0;
                        sum_ff    <= '0;
                        state_ff  <= S_READ;
                     end
                     dist_ff <= '0;
                  end else begin
                  end
               end
            end
            S_READ: begin
               // Address (i, j) is presented now; data arrives next cycle.
               best_ff  <= '1;
               pend_ff  <= 1'b1;
               last_ff  <= (j_ff + 1'b1 == n_in);
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (d2 < best_ff) best_ff <= d2;
               if (last_ff) begin
                  pend_ff  <= 1'b0;
                  state_ff <= S_SQRT;
               end else begin
                  last_ff <= (j_ff + 1'b1 == n_in);
                  j_ff    <= j_ff + 1'b1;
               end
            end
            S_SQRT: begin
               if (sq_done) begin
                  sum_ff <= sum_ff + SUMB'(sq_root);
                  j_ff   <= '0;
                  if (i_ff + 1'b1 == n_out) begin
                     state_ff <= S_DIV;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_READ;
                  end
               end
            end
            S_DIV: begin
               if (dv_done) begin
                  if (!dir_ff) begin
                     fwd_ff   <= dv_quot;
                     state_ff <= S_NEXTDIR;
                  end else begin
                     dist_ff  <= (total[SUMB:1] > (SUMB)'(DMAX)) ?
                                 cdps_pkg::DIST_BITS'(DMAX) :
                                 cdps_pkg::DIST_BITS'(total[SUMB:1]);
                     state_ff <= S_RESP;
                  end
               end
            end
            S_NEXTDIR: begin
               dir_ff   <= 1'b1;
               i_ff     <= '0;
               j_ff     <= '0;
               sum_ff   <= '0;
               state_ff <= S_READ;
            end
            S_RESP: begin
               cnt_a_ff     <= '0;
               cnt_b_ff     <= '0;
               ovf_ff       <= 1'b0;
               dir_ff       <= 1'b0;
               state_ff     <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign distance_q8 = dist_ff;
   assign status      = status_ff;
endmodule
`default_nettype wire

/* src/cdps_point_ram.sv */
// One point store: single write port, single registered read port.
// Depends on nothing but its parameters.
`default_nettype none
module cdps_point_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 22
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/cdps_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on nothing but its parameter IN_BITS (even).
`default_nettype none
module cdps_isqrt #(
   parameter int IN_BITS = 40
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [IN_BITS-1:0]   radicand,
   output logic                      done,
   output logic      [IN_BITS/2-1:0] root
);
   localparam int RB = IN_BITS / 2;
   localparam int CB = $clog2(RB + 1);
   logic [IN_BITS-1:0] rem_ff;
   logic [IN_BITS-1:0] src_ff;
   logic [RB-1:0]      root_ff;
   logic [CB-1:0]      cnt_ff;
   logic               busy_ff;
   logic [IN_BITS+1:0] trial;
   logic [IN_BITS+1:0] shifted;

   // Restoring method: bring down two radicand bits, try root*4+1.
   always_comb begin
      shifted = {rem_ff, src_ff[IN_BITS-1 -: 2]};
      trial   = {{(IN_BITS+2-RB-2){1'b0}}, root_ff, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done    <= 1'b0;
         rem_ff  <= '0;
         src_ff  <= radicand;
         root_ff <= '0;
         cnt_ff  <= CB'(RB);
      end else if (busy_ff) begin
         src_ff <= src_ff << 2;
         if (shifted >= trial) begin
            rem_ff  <= IN_BITS'(shifted - trial);
            root_ff <= {root_ff[RB-2:0], 1'b1};
         end else begin
            rem_ff  <= IN_BITS'(shifted);
            root_ff <= {root_ff[RB-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         done   <= (cnt_ff == CB'(1));
         if (cnt_ff == CB'(1)) busy_ff <= 1'b0;
      end else begin
         done <= 1'b0;
      end
   end
   assign root = root_ff;
endmodule
`default_nettype wire

/* src/cdps_divider.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none
module cdps_divider #(
   parameter int NUM_BITS = 32,
   parameter int DEN_BITS = 9
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] numer,
   input  wire logic [DEN_BITS-1:0] denom,
   output logic                     done,
   output logic      [NUM_BITS-1:0] quot
);
   localparam int CB = $clog2(NUM_BITS + 1);
   logic [NUM_BITS-1:0] q_ff;
   logic [DEN_BITS:0]   r_ff;
   logic [DEN_BITS-1:0] d_ff;
   logic [CB-1:0]       cnt_ff;
   logic                busy_ff;
   logic [DEN_BITS:0]   r_sh;

   assign r_sh = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done    <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done    <= 1'b0;
         q_ff    <= numer;
         r_ff    <= '0;
         d_ff    <= denom;
         cnt_ff  <= CB'(NUM_BITS);
      end else if (busy_ff) begin
         if (r_sh >= {1'b0, d_ff}) begin
            r_ff <= r_sh - {1'b0, d_ff};
            q_ff <= {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_ff <= r_sh;
            q_ff <= {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         done   <= (cnt_ff == CB'(1));
         if (cnt_ff == CB'(1)) busy_ff <= 1'b0;
      end else begin
         done <= 1'b0;
      end
   end
   assign quot = q_ff;
endmodule
`default_nettype wire

/* src/cdps_checker.sv */
// Port-level checker for the chamfer distance block, bound to the top level.
// Depends on assert_macros.svh and cdps_pkg.
`default_nettype none
`include "assert_macros.svh"
module cdps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic [1:0] req_type,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [cdps_pkg::DIST_BITS-1:0] distance_q8,
   input wire logic [1:0] status
);
   logic rsp_err;
   logic status_known;
   logic compute_blocked;

   assign rsp_err = rsp_valid && status != cdps_pkg::ST_OK;
   assign status_known = status == cdps_pkg::ST_OK || status == cdps_pkg::ST_EMPTY
                         || status == cdps_pkg::ST_DROPPED;
   // A compute word may not enter while the previous result word still waits.
   assign compute_blocked = req_valid && rsp_valid && req_type == cdps_pkg::REQ_COMPUTE;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(distance_q8))
   `ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, status_known)
   `ASSERT_IMPL(a_error_zero, clock, reset, rsp_err, distance_q8 == '0)
   `ASSERT_IMPL(a_busy_while_pending, clock, reset, compute_blocked, req_stall)
endmodule
bind chamfer_distance_point_sets cdps_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .distance_q8(distance_q8), .status(status));
`default_nettype wire
